FILE: design/mart_pkg.sv
// Package for the MAC address remap table: sizes, generator constants,
// outcome codes, register indexes, sequencer states and the generator control struct.
// No dependencies.
`default_nettype none
package mart_pkg;

   localparam int TABLE_DEPTH = 16;
   localparam int MAC_W       = 48;
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
   localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 32;
   localparam int GEN_W       = 32;
   localparam int MAC_BYTES   = 6;

   localparam logic [GEN_W-1:0] LCG_MUL = 32'd1664525;
   localparam logic [GEN_W-1:0] LCG_ADD = 32'd1013904223;

   localparam logic [7:0] FIRST_BYTE_MASK = 8'hFE;
   localparam logic [7:0] FIRST_BYTE_SET  = 8'h02;
   localparam logic [7:0] MCAST_B0        = 8'h01;
   localparam logic [7:0] MCAST_B1        = 8'h00;
   localparam logic [7:0] MCAST_B2        = 8'h5E;
   localparam logic [MAC_W-1:0] BCAST_MAC = 48'hFFFF_FFFF_FFFF;

   localparam logic [CSR_IDX_W-1:0] CSR_SEED   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FILTER = 2'd1;

   typedef enum logic [2:0] {
      OUT_HIT_ORIG = 3'd0,
      OUT_HIT_REPL = 3'd1,
      OUT_NEW      = 3'd2,
      OUT_FULL     = 3'd3,
      OUT_FILTERED = 3'd4
   } outcome_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_SEARCH,
      ST_GEN,
      ST_WRITE,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic             load;
      logic             step;
      logic [GEN_W-1:0] seed;
   } lcg_ctrl_type;

endpackage
`default_nettype wire

FILE: design/mart_lcg.sv
// Generator unit: 32-bit linear congruential state, one step per cycle on step.
// Depends on mart_pkg.
`default_nettype none
module mart_lcg (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire mart_pkg::lcg_ctrl_type ctrl,
   output logic [7:0]               step_byte
);
   import mart_pkg::*;

   logic [GEN_W-1:0] state_ff;
   logic [GEN_W-1:0] state_in;
   logic [GEN_W-1:0] next_state;

   assign next_state = state_ff * LCG_MUL + LCG_ADD;
   assign step_byte  = next_state[7:0];

   always_comb begin
      state_in = state_ff;
      if (ctrl.load) begin
         state_in = ctrl.seed;
      end else if (ctrl.step) begin
         state_in = next_state;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

FILE: design/mac_address_remap_table_unit.sv
// Top level of the MAC address remap table: sequencer, entry memory, filter.
// Depends on mart_pkg and mart_lcg.
//
//   channel  | handshake              | payload
//   ---------+------------------------+------------------------------
//   request  | req_valid / req_ready  | req_mac_in[47:0]
//   response | rsp_valid / rsp_ready  | rsp_mac_out[47:0], rsp_outcome[2:0]
//   csr      | csr_we                 | csr_index[1:0], csr_wdata[31:0]
//
// One transaction at a time: req_ready is high only while idle.
// A filtered address goes from the check state straight to the response. Search: one entry per
// cycle through the registered memory read; a new entry adds 6 generator steps and
// then a write state before the response.
// Reset clears the entry count, loads the generator with 0 and enables the filter.
// A stalled response holds until rsp_ready.
`default_nettype none
module mac_address_remap_table_unit (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic [mart_pkg::MAC_W-1:0]         req_mac_in,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic [mart_pkg::MAC_W-1:0]              rsp_mac_out,
   output logic [2:0]                              rsp_outcome,
   input  wire logic                               csr_we,
   input  wire logic [mart_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [mart_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import mart_pkg::*;

   state_type         state_ff, state_in;
   logic [MAC_W-1:0]  mac_ff, mac_in;
   logic [MAC_W-1:0]  res_ff, res_in;
   outcome_type       code_ff, code_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic              rd_vld_ff, rd_vld_in;
   logic [2:0]        gen_cnt_ff, gen_cnt_in;
   logic              filter_ff, filter_in;

   logic [MAC_W-1:0]  orig_mem [TABLE_DEPTH];
   logic [MAC_W-1:0]  repl_mem [TABLE_DEPTH];
   logic [MAC_W-1:0]  orig_rd_ff;
   logic [MAC_W-1:0]  repl_rd_ff;
   logic              mem_we;

   lcg_ctrl_type      lcg_ctrl;
   logic [7:0]        step_byte;
   logic [7:0]        gen_byte;
   logic              is_filtered;

   function automatic logic filter_hit(input logic [MAC_W-1:0] mac);
      logic [2:0] zeros;
      zeros = '0;
      for (int i = 0; i < MAC_BYTES; i++) begin
         if (mac[8*i +: 8] == 8'd0) begin
            zeros = zeros + 3'd1;
         end
      end
      return (mac == BCAST_MAC) ||
             (mac[47:40] == MCAST_B0 && mac[39:32] == MCAST_B1 && mac[31:24] == MCAST_B2) ||
             (zeros > 3'd1);
   endfunction

   mart_lcg u_lcg (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (lcg_ctrl),
      .step_byte (step_byte)
   );

   assign is_filtered = filter_ff && filter_hit(mac_ff);
   assign gen_byte    = (gen_cnt_ff == 3'd0) ?
                        ((step_byte & FIRST_BYTE_MASK) | FIRST_BYTE_SET) : step_byte;

   assign req_ready   = (state_ff == ST_IDLE);
   assign rsp_valid   = (state_ff == ST_RESP);
   assign rsp_mac_out = res_ff;
   assign rsp_outcome = code_ff;

   always_comb begin
      state_in      = state_ff;
      mac_in        = mac_ff;
      res_in        = res_ff;
      code_in       = code_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      rd_vld_in     = 1'b0;
      gen_cnt_in    = gen_cnt_ff;
      filter_in     = filter_ff;
      mem_we        = 1'b0;
      lcg_ctrl.load = 1'b0;
      lcg_ctrl.step = 1'b0;
      lcg_ctrl.seed = csr_wdata;

      if (csr_we) begin
         case (csr_index)
            CSR_SEED:   lcg_ctrl.load = 1'b1;
            CSR_FILTER: filter_in     = csr_wdata[0];
            default:    ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               mac_in   = req_mac_in;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            idx_in = '0;
            if (is_filtered) begin
               res_in   = mac_ff;
               code_in  = OUT_FILTERED;
               state_in = ST_RESP;
            end else begin
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (rd_vld_ff && orig_rd_ff == mac_ff) begin
               res_in   = repl_rd_ff;
               code_in  = OUT_HIT_ORIG;
               state_in = ST_RESP;
            end else if (rd_vld_ff && repl_rd_ff == mac_ff) begin
               res_in   = repl_rd_ff;
               code_in  = OUT_HIT_REPL;
               state_in = ST_RESP;
            end else if (idx_ff < count_ff) begin
               rd_vld_in = 1'b1;
               idx_in    = idx_ff + 1'b1;
            end else if (!rd_vld_ff) begin
               if (count_ff < CNT_W'(TABLE_DEPTH)) begin
                  gen_cnt_in = '0;
                  state_in   = ST_GEN;
               end else begin
                  res_in   = mac_ff;
                  code_in  = OUT_FULL;
                  state_in = ST_RESP;
               end
            end
         end
         ST_GEN: begin
            lcg_ctrl.step = 1'b1;
            res_in        = {res_ff[MAC_W-9:0], gen_byte};
            gen_cnt_in    = gen_cnt_ff + 3'd1;
            if (gen_cnt_ff == 3'(MAC_BYTES - 1)) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            mem_we   = 1'b1;
            count_in = count_ff + 1'b1;
            code_in  = OUT_NEW;
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         count_ff  <= '0;
         rd_vld_ff <= 1'b0;
         filter_ff <= 1'b1;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         rd_vld_ff <= rd_vld_in;
         filter_ff <= filter_in;
      end
   end

   always_ff @(posedge clock) begin
      mac_ff     <= mac_in;
      res_ff     <= res_in;
      code_ff    <= code_in;
      idx_ff     <= idx_in;
      gen_cnt_ff <= gen_cnt_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         orig_mem[count_ff[ADDR_W-1:0]] <= mac_ff;
         repl_mem[count_ff[ADDR_W-1:0]] <= res_ff;
      end
      orig_rd_ff <= orig_mem[idx_ff[ADDR_W-1:0]];
      repl_rd_ff <= repl_mem[idx_ff[ADDR_W-1:0]];
   end

endmodule
`default_nettype wire

FILE: tb/mac_address_remap_table_unit_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for mac_address_remap_table_unit: directed and random lookups
// checked against an in-bench remap predictor. Depends on mart_pkg and the unit.
module mac_address_remap_table_unit_tb;
   import mart_pkg::*;

   localparam int STALL_LIMIT  = 4000;
   localparam int RANDOM_ITEMS = 1900;
   localparam int PHASES       = 8;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_3 = 2'd3;

   typedef struct packed {
      logic [MAC_W-1:0] mac;
      outcome_type      code;
   } remap_result_type;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_valid   = 1'b0;
   logic                  req_ready;
   logic [MAC_W-1:0]      req_mac_in  = '0;
   logic                  rsp_valid;
   logic                  rsp_ready   = 1'b0;
   logic [MAC_W-1:0]      rsp_mac_out;
   logic [2:0]            rsp_outcome;
   logic                  csr_we      = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index   = '0;
   logic [CSR_DATA_W-1:0] csr_wdata   = '0;

   // predictor state
   logic [MAC_W-1:0] orig_entries [TABLE_DEPTH];
   logic [MAC_W-1:0] repl_entries [TABLE_DEPTH];
   int               entry_total = 0;
   logic [GEN_W-1:0] lcg_state   = '0;
   logic             filter_on   = 1'b1;

   remap_result_type pending_remaps [$];
   remap_result_type want;
   int               mismatch_count = 0;
   int               idle_cycles    = 0;
   int               send_idle_pct  = 0;
   int               rsp_stall_pct  = 0;

   mac_address_remap_table_unit DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_mac_in  (req_mac_in),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_mac_out (rsp_mac_out),
      .rsp_outcome (rsp_outcome),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always #2 clock = ~clock;

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_remaps.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected response: mac %h outcome %0d", rsp_mac_out, rsp_outcome);
         end else begin
            want = pending_remaps.pop_front();
            if (rsp_mac_out !== want.mac || rsp_outcome !== want.code) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: expected mac %h outcome %0d, got mac %h outcome %0d",
                           want.mac, want.code, rsp_mac_out, rsp_outcome);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("mac_address_remap_table_unit_tb failed");
         $finish;
      end
   end

   function automatic logic [MAC_W-1:0] lcg_address(inout logic [GEN_W-1:0] st);
      logic [MAC_W-1:0] mac;
      logic [7:0]       b;
      mac = '0;
      for (int i = 0; i < MAC_BYTES; i++) begin
         st = st * LCG_MUL + LCG_ADD;
         b  = st[7:0];
         if (i == 0)
            b = (b & FIRST_BYTE_MASK) | FIRST_BYTE_SET;
         mac = {mac[MAC_W-9:0], b};
      end
      return mac;
   endfunction

   function automatic logic is_passthrough(input logic [MAC_W-1:0] mac);
      int zeros;
      zeros = 0;
      for (int i = 0; i < MAC_BYTES; i++)
         if (mac[8*i +: 8] == 8'h00)
            zeros++;
      return (mac == BCAST_MAC) || (mac[47:24] == {MCAST_B0, MCAST_B1, MCAST_B2}) || (zeros > 1);
   endfunction

   function automatic remap_result_type predict_remap(input logic [MAC_W-1:0] mac);
      remap_result_type res;
      logic             hit;
      res.mac  = mac;
      res.code = OUT_FULL;
      hit      = 1'b0;
      if (filter_on && is_passthrough(mac)) begin
         res.code = OUT_FILTERED;
      end else begin
         for (int k = 0; k < entry_total && !hit; k++) begin
            if (orig_entries[k] == mac) begin
               res.mac  = repl_entries[k];
               res.code = OUT_HIT_ORIG;
               hit      = 1'b1;
            end else if (repl_entries[k] == mac) begin
               res.mac  = repl_entries[k];
               res.code = OUT_HIT_REPL;
               hit      = 1'b1;
            end
         end
         if (!hit && entry_total < TABLE_DEPTH) begin
            res.mac                   = lcg_address(lcg_state);
            orig_entries[entry_total] = mac;
            repl_entries[entry_total] = res.mac;
            entry_total++;
            res.code = OUT_NEW;
         end
      end
      return res;
   endfunction

   function automatic logic [MAC_W-1:0] random_mac();
      logic [63:0] raw;
      raw = {$urandom(), $urandom()};
      return raw[MAC_W-1:0];
   endfunction

   function automatic logic [MAC_W-1:0] sparse_mac(input logic [MAC_W-1:0] mac);
      int p;
      int q;
      p = $urandom_range(5);
      q = (p + 1 + $urandom_range(4)) % MAC_BYTES;
      mac[8*p +: 8] = 8'h00;
      mac[8*q +: 8] = 8'h00;
      if ($urandom_range(1))
         mac[8*$urandom_range(5) +: 8] = 8'h00;
      return mac;
   endfunction

   function automatic logic [MAC_W-1:0] pick_mac();
      int               sel;
      logic [MAC_W-1:0] mac;
      mac = random_mac();
      sel = $urandom_range(99);
      if (entry_total > 0 && sel < 25)
         mac = orig_entries[$urandom_range(entry_total - 1)];
      else if (entry_total > 0 && sel < 45)
         mac = repl_entries[$urandom_range(entry_total - 1)];
      else if (entry_total > 0 && sel < 52)
         mac = orig_entries[$urandom_range(entry_total - 1)] ^ (48'd1 << $urandom_range(47));
      else if (sel < 58)
         mac = BCAST_MAC;
      else if (sel < 65)
         mac[47:24] = {MCAST_B0, MCAST_B1, MCAST_B2};
      else if (sel < 75)
         mac = sparse_mac(mac);
      else if (sel < 80)
         mac[8*$urandom_range(5) +: 8] = 8'h00;
      return mac;
   endfunction

   task automatic send_mac(input logic [MAC_W-1:0] mac);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct)
         gap++;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid  <= 1'b1;
      req_mac_in <= mac;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      pending_remaps.push_back(predict_remap(mac));
   endtask

   task automatic drain_responses();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_remaps.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] value);
      drain_responses();
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         CSR_SEED:   lcg_state = value;
         CSR_FILTER: filter_on = value[0];
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic test_filter_passthrough();
      send_mac(BCAST_MAC);
      send_mac(48'h01_00_5E_12_34_56);
      send_mac(48'h0);
      send_mac(48'h01_00_5F_AB_CD_EF);
      send_mac(48'h00_11_22_33_44_55);
      send_mac(orig_entries[0]);
      send_mac(repl_entries[0]);
   endtask

   task automatic test_unknown_register();
      write_register(CSR_SPARE_2, 32'h0);
      write_register(CSR_SPARE_3, 32'hFFFF_FFFF);
      send_mac(BCAST_MAC);
      send_mac(48'hA5_5A_C3_3C_96_69);
   endtask

   task automatic test_seed_extremes();
      write_register(CSR_SEED, 32'hFFFF_FFFF);
      send_mac(48'hFE_DC_BA_98_76_54);
      send_mac(48'h12_34_56_78_9A_BC);
      // reseed to 0: the new entry repeats the first replacement, first entry wins
      write_register(CSR_SEED, 32'h0);
      send_mac(48'h7E_7E_7E_7E_7E_7E);
      send_mac(repl_entries[0]);
   endtask

   task automatic test_filter_disabled();
      write_register(CSR_FILTER, 32'd0);
      send_mac(BCAST_MAC);
      send_mac(48'h01_00_5E_00_00_01);
      send_mac(48'h0);
   endtask

   task automatic test_double_match();
      logic [GEN_W-1:0] seed;
      logic [GEN_W-1:0] probe;
      logic [MAC_W-1:0] target;
      seed   = $urandom();
      probe  = seed;
      target = lcg_address(probe);
      // store target as an original, then make a later entry draw it as its replacement
      write_register(CSR_SEED, seed ^ 32'h0000_0001);
      send_mac(target);
      write_register(CSR_SEED, seed);
      send_mac(random_mac());
      send_mac(target);
   endtask

   task automatic test_table_full();
      while (entry_total < TABLE_DEPTH)
         send_mac(random_mac());
      send_mac(random_mac());
      send_mac(orig_entries[TABLE_DEPTH-1]);
   endtask

   task automatic test_random_traffic();
      for (int phase = 0; phase < PHASES; phase++) begin
         write_register(CSR_FILTER, (phase % 2 == 0) ? 32'd1 : 32'd0);
         case (phase % 3)
            0:       write_register(CSR_SEED, $urandom());
            1:       write_register(CSR_SEED, 32'hFFFF_FFFF);
            default: write_register(CSR_SEED, 32'h0);
         endcase
         case (phase % 4)
            0:       begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1:       begin send_idle_pct = 45; rsp_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  rsp_stall_pct = 45; end
            default: begin send_idle_pct = 11; rsp_stall_pct = 11; end
         endcase
         repeat (RANDOM_ITEMS / PHASES)
            send_mac(pick_mac());
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_filter_passthrough();
      test_unknown_register();
      test_seed_extremes();
      test_filter_disabled();
      test_double_match();
      test_table_full();
      test_random_traffic();
      drain_responses();
      repeat (TABLE_DEPTH + 10) @(posedge clock);
      if (mismatch_count == 0 && pending_remaps.size() == 0)
         $display("mac_address_remap_table_unit_tb passed");
      else
         $display("mac_address_remap_table_unit_tb failed");
      $finish;
   end

endmodule

FILE: filelist.f
design/mart_pkg.sv
design/mart_lcg.sv
design/mac_address_remap_table_unit.sv
tb/mac_address_remap_table_unit_tb.sv
